/* rtl/dhtfr_pkg.sv */
// Shared types and codes for the single-wire sensor frame receiver.
package dhtfr_pkg;

  localparam int unsigned FrameBits = 40;
  localparam int unsigned BitIdxW   = 6;
  localparam int unsigned PhaseW    = 3;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 16;

  // Phase codes
  localparam logic [PhaseW-1:0] PH_IDLE  = 3'd0;
  localparam logic [PhaseW-1:0] PH_READY = 3'd1;
  localparam logic [PhaseW-1:0] PH_ERROR = 3'd2;
  localparam logic [PhaseW-1:0] PH_HOLD  = 3'd3;
  localparam logic [PhaseW-1:0] PH_ACK   = 3'd4;
  localparam logic [PhaseW-1:0] PH_RESP  = 3'd5;
  localparam logic [PhaseW-1:0] PH_RECV  = 3'd6;

  // Function codes of an input word
  localparam logic [1:0] FUNC_START = 2'd0;
  localparam logic [1:0] FUNC_TICK  = 2'd1;
  localparam logic [1:0] FUNC_EDGE  = 2'd2;
  localparam logic [1:0] FUNC_POLL  = 2'd3;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_PIN_MASK   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_HOLD_TICKS = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_ACK_LIMIT  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_RESP_LIMIT = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_BIT_LIMIT  = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_ONE_THRESH = 3'd5;

  typedef struct packed {
    logic [15:0] pin_mask;
    logic [7:0]  start_hold_ticks;
    logic [15:0] ack_limit_us;
    logic [15:0] response_limit_us;
    logic [15:0] bit_limit_us;
    logic [15:0] one_threshold_us;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] edge_pin;
    logic [15:0] interval_us;
  } item_t;

  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic              line_drive_low;
    logic              edge_listen;
    logic              interval_restart;
    logic              has_data;
    logic [7:0]        humidity_whole;
    logic [7:0]        humidity_tenths;
    logic [7:0]        temperature_whole;
    logic [7:0]        temperature_tenths;
  } result_t;

endpackage

/* rtl/dhtfr_cfg_regs.sv */
// Configuration register file of the sensor frame receiver.
module dhtfr_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [dhtfr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [dhtfr_pkg::CfgDataW-1:0] cfg_wdata_i,
  output dhtfr_pkg::cfg_t                cfg_o
);
  import dhtfr_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PIN_MASK:   cfg_d.pin_mask          = cfg_wdata_i;
        CFG_HOLD_TICKS: cfg_d.start_hold_ticks  = cfg_wdata_i[7:0];
        CFG_ACK_LIMIT:  cfg_d.ack_limit_us      = cfg_wdata_i;
        CFG_RESP_LIMIT: cfg_d.response_limit_us = cfg_wdata_i;
        CFG_BIT_LIMIT:  cfg_d.bit_limit_us      = cfg_wdata_i;
        CFG_ONE_THRESH: cfg_d.one_threshold_us  = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pin_mask          <= 16'd32;
      cfg_q.start_hold_ticks  <= 8'd19;
      cfg_q.ack_limit_us      <= 16'd50;
      cfg_q.response_limit_us <= 16'd200;
      cfg_q.bit_limit_us      <= 16'd140;
      cfg_q.one_threshold_us  <= 16'd100;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/dhtfr_core.sv */
// Phase state machine, bit shifter and checksum check of the receiver.
module dhtfr_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  dhtfr_pkg::item_t   item_i,
  input  dhtfr_pkg::cfg_t    cfg_i,
  output dhtfr_pkg::result_t res_o
);
  import dhtfr_pkg::*;

  logic [PhaseW-1:0]    phase_q, phase_d;
  logic [7:0]           hold_q, hold_d;
  logic [BitIdxW-1:0]   bit_idx_q, bit_idx_d;
  logic [FrameBits-1:0] shift_q, shift_d;
  logic [31:0]          reading_q, reading_d;

  logic [7:0]           hold_inc;
  logic [BitIdxW-1:0]   bit_inc;
  logic                 bit_val;
  logic [FrameBits-1:0] shift_next;
  logic [7:0]           csum;
  logic                 restart;
  logic                 has_data;
  logic                 listening;

  assign hold_inc   = hold_q + 8'd1;
  assign bit_inc    = bit_idx_q + BitIdxW'(1);
  assign bit_val    = item_i.interval_us > cfg_i.one_threshold_us;
  assign shift_next = {shift_q[FrameBits-2:0], bit_val};
  assign csum       = shift_next[39:32] + shift_next[31:24] + shift_next[23:16]
                      + shift_next[15:8];
  assign listening  = (phase_q == PH_ACK) || (phase_q == PH_RESP) || (phase_q == PH_RECV);

  always_comb begin
    phase_d   = phase_q;
    hold_d    = hold_q;
    bit_idx_d = bit_idx_q;
    shift_d   = shift_q;
    reading_d = reading_q;
    restart   = 1'b0;
    has_data  = 1'b0;

    unique case (item_i.func)
      FUNC_START: begin
        phase_d = PH_HOLD;
        hold_d  = 8'd0;
      end
      FUNC_TICK: begin
        if (phase_q == PH_HOLD) begin
          hold_d = hold_inc;
          if (hold_inc >= cfg_i.start_hold_ticks) begin
            phase_d = PH_ACK;
            hold_d  = 8'd0;
            restart = 1'b1;
          end
        end
      end
      FUNC_EDGE: begin
        if (item_i.edge_pin == cfg_i.pin_mask && listening) begin
          restart = 1'b1;
          case (phase_q)
            PH_ACK: begin
              phase_d = (item_i.interval_us > cfg_i.ack_limit_us) ? PH_ERROR : PH_RESP;
            end
            PH_RESP: begin
              if (item_i.interval_us > cfg_i.response_limit_us) begin
                phase_d = PH_ERROR;
              end else begin
                shift_d   = '0;
                bit_idx_d = '0;
                phase_d   = PH_RECV;
              end
            end
            default: begin
              // receiving a data bit
              if (item_i.interval_us > cfg_i.bit_limit_us) begin
                phase_d = PH_ERROR;
              end else begin
                shift_d   = shift_next;
                bit_idx_d = bit_inc;
                if (bit_inc >= BitIdxW'(FrameBits)) begin
                  if (csum == shift_next[7:0]) begin
                    reading_d = shift_next[39:8];
                    phase_d   = PH_READY;
                  end else begin
                    phase_d = PH_ERROR;
                  end
                end
              end
            end
          endcase
        end
      end
      default: begin
        if (phase_q == PH_READY) begin
          has_data = 1'b1;
          phase_d  = PH_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      hold_q    <= '0;
      bit_idx_q <= '0;
      shift_q   <= '0;
      reading_q <= '0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      hold_q    <= hold_d;
      bit_idx_q <= bit_idx_d;
      shift_q   <= shift_d;
      reading_q <= reading_d;
    end
  end

  always_comb begin
    res_o.phase              = phase_d;
    res_o.line_drive_low     = (phase_d == PH_HOLD);
    res_o.edge_listen        = (phase_d == PH_ACK) || (phase_d == PH_RESP)
                               || (phase_d == PH_RECV);
    res_o.interval_restart   = restart;
    res_o.has_data           = has_data;
    res_o.humidity_whole     = reading_d[31:24];
    res_o.humidity_tenths    = reading_d[23:16];
    res_o.temperature_whole  = reading_d[15:8];
    res_o.temperature_tenths = reading_d[7:0];
  end

endmodule

/* rtl/dht_sensor_frame_receiver_unit.sv */
// Top level of the single-wire humidity and temperature sensor frame receiver.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+---------------------------------------
//  in      | input     | in_valid_i / in_ready_o | func, edge_pin, interval_us
//  out     | output    | out_valid_o/out_ready_i | phase, line/listen/restart/has_data,
//          |           |                         | humidity and temperature bytes
//  cfg     | input     | cfg_we_i                | cfg_idx_i, cfg_wdata_i
//
// A word is held in the input register, then the phase logic runs and the result
// lands in the output register; one word per cycle while the output is not stalled.
// The input register only advances while the output register is empty or being
// taken, so an output stall holds one word in each register and then drops in_ready_o.
// Reset clears the valid flags, the phase state and the configuration to defaults.
module dht_sensor_frame_receiver_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [dhtfr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [dhtfr_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [1:0]                     func_i,
  input  logic [15:0]                    edge_pin_i,
  input  logic [15:0]                    interval_us_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [dhtfr_pkg::PhaseW-1:0]   phase_o,
  output logic                           line_drive_low_o,
  output logic                           edge_listen_o,
  output logic                           interval_restart_o,
  output logic                           has_data_o,
  output logic [7:0]                     humidity_whole_o,
  output logic [7:0]                     humidity_tenths_o,
  output logic [7:0]                     temperature_whole_o,
  output logic [7:0]                     temperature_tenths_o
);
  import dhtfr_pkg::*;

  cfg_t    cfg;
  item_t   item_q;
  logic    in_vld_q;
  result_t res, res_q;
  logic    out_vld_q;
  logic    step;

  assign step       = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || step;

  dhtfr_cfg_regs u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .cfg_o (cfg)
  );

  dhtfr_core u_core (
    .clk_i,
    .rst_ni,
    .step_i (step),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (step) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.func        <= func_i;
      item_q.edge_pin    <= edge_pin_i;
      item_q.interval_us <= interval_us_i;
    end
    if (step) begin
      res_q <= res;
    end
  end

  assign out_valid_o          = out_vld_q;
  assign phase_o              = res_q.phase;
  assign line_drive_low_o     = res_q.line_drive_low;
  assign edge_listen_o        = res_q.edge_listen;
  assign interval_restart_o   = res_q.interval_restart;
  assign has_data_o           = res_q.has_data;
  assign humidity_whole_o     = res_q.humidity_whole;
  assign humidity_tenths_o    = res_q.humidity_tenths;
  assign temperature_whole_o  = res_q.temperature_whole;
  assign temperature_tenths_o = res_q.temperature_tenths;

endmodule
